/* design/ipal_pkg.sv */
// Package for the indexed palette register file: bus decode constants,
// table geometry, controller state type and controller/datapath structs.
// No dependencies.
package ipal_pkg;

    // Table geometry; the depth is a power of two from 16 to 4096
    localparam int PAL_ENTRIES = 4096;
    localparam int PAL_ADDR_W  = $clog2(PAL_ENTRIES);
    localparam int LEVEL_W     = 4;
    localparam int ENTRY_W     = 3 * LEVEL_W;
    localparam int INDEX_W     = 12;

    // Bus decode window
    localparam logic [15:0] ADDR_FIRST = 16'hFD30;
    localparam logic [15:0] ADDR_LAST  = 16'hFD34;

    // Register offsets inside the window
    localparam logic [2:0] OFF_IDX_HI = 3'd0;
    localparam logic [2:0] OFF_IDX_LO = 3'd1;
    localparam logic [2:0] OFF_BLUE   = 3'd2;
    localparam logic [2:0] OFF_RED    = 3'd3;
    localparam logic [2:0] OFF_GREEN  = 3'd4;

    // Request kind
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Read data patterns
    localparam logic [7:0] RD_UPPER_ONES = 8'hF0;
    localparam logic [7:0] RD_ALL_ONES   = 8'hFF;

    // Configuration registers
    localparam logic       CFG_IDX_VERSION    = 1'b0;
    localparam logic       CFG_IDX_FULL_COLOR = 1'b1;
    localparam logic [1:0] VER_NONE           = 2'd0;
    localparam logic [1:0] VER_WRITE_ONLY     = 2'd1;
    localparam logic [1:0] VER_RESET          = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_LOOKUP = 4'b0100,
        ST_RESULT = 4'b1000
    } ipal_state_t;

    typedef struct packed {
        logic clear_step;   // write zero at the sweep address, advance
        logic capture;      // latch the request, start the table read
        logic resolve;      // form the result, write back the table
    } ipal_cmd_t;

    typedef struct packed {
        logic clear_last;   // sweep is at the final entry
    } ipal_status_t;

endpackage

/* design/indexed_palette_register_file_unit.sv */
// Top level of the indexed palette register file.
// Depends on ipal_pkg, ipal_ctrl and ipal_datapath.

// Bus-mapped color palette at 0xFD30..0xFD34 (index high nibble, index low
// byte, blue, red and green level of the selected entry), with a 4096-entry
// level table held in one RAM that stores the three levels of an entry side
// by side. After reset the block sweeps the RAM to zero, one entry a cycle,
// and accepts no request meanwhile; configuration writes are taken at any
// time. Each request then passes through the accept state, the lookup state
// that holds the registered RAM read and in which the result and the level
// write-back are formed, and the result state that presents the result. The
// result is held, with the input blocked, for however long out_ready stays
// low, so a new request is taken only after the previous result has been
// taken. One request is in the block at a time.
module indexed_palette_register_file_unit
    import ipal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [15:0] bus_addr,
    input  logic [7:0]  wr_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  rd_data,
    output logic        claimed,
    output logic        notify
);

    ipal_cmd_t    cmd;
    ipal_status_t status;

    assign cfg_ready = 1'b1;

    ipal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ipal_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_type  (req_type),
        .bus_addr  (bus_addr),
        .wr_data   (wr_data),
        .rd_data   (rd_data),
        .claimed   (claimed),
        .notify    (notify)
    );

endmodule

/* design/ipal_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ipal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/ipal_ctrl.sv */
// Controller for the indexed palette: clearing sweep after reset, then
// one request at a time through capture, table lookup and result hold.
// Depends on ipal_pkg.
module ipal_ctrl
    import ipal_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  ipal_status_t status,
    output ipal_cmd_t    cmd
);

    ipal_state_t state_reg;
    ipal_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = (state_reg == ST_RESULT);
    assign cmd.clear_step = (state_reg == ST_CLEAR);
    assign cmd.capture    = in_ready && in_valid;
    assign cmd.resolve    = (state_reg == ST_LOOKUP);

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    a_capture_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.resolve)
        else $error("accepted request did not enter table lookup");

    a_lookup_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.resolve |=> out_valid && !in_ready)
        else $error("lookup did not present a result");

    a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step && status.clear_last |=> in_ready)
        else $error("clearing sweep did not hand over to idle");

endmodule

/* design/ipal_datapath.sv */
// Datapath for the indexed palette: configuration registers, entry index,
// the combined B/R/G level RAM with its clearing counter, and result regs.
// Depends on ipal_pkg and ipal_ram.
module ipal_datapath
    import ipal_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ipal_cmd_t    cmd,
    output ipal_status_t status,
    input  logic         cfg_valid,
    input  logic         cfg_index,
    input  logic [1:0]   cfg_data,
    input  logic         req_type,
    input  logic [15:0]  bus_addr,
    input  logic [7:0]   wr_data,
    output logic [7:0]   rd_data,
    output logic         claimed,
    output logic         notify
);

    logic [1:0]            version_reg;
    logic                  full_color_reg;
    logic [INDEX_W-1:0]    index_reg;
    logic [INDEX_W-1:0]    index_next;
    logic [PAL_ADDR_W-1:0] clr_cnt_reg;

    logic                  hit_reg;
    logic                  type_reg;
    logic [2:0]            off_reg;
    logic [7:0]            wdata_reg;

    logic [7:0]            rd_data_reg;
    logic [7:0]            rd_data_next;
    logic                  claimed_reg;
    logic                  notify_reg;
    logic                  notify_next;

    logic [PAL_ADDR_W-1:0] slot;
    logic [ENTRY_W-1:0]    entry_old;
    logic [ENTRY_W-1:0]    entry_new;
    logic                  level_wr;
    logic                  ram_we;
    logic [PAL_ADDR_W-1:0] ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [LEVEL_W-1:0]    wr_level;

    // Depth is a power of two, so the modulo is the low index bits
    assign slot     = index_reg[PAL_ADDR_W-1:0];
    assign wr_level = wdata_reg[LEVEL_W-1:0];

    // Entry layout: blue, red, green from the top
    always_comb
    begin
        entry_new = entry_old;
        level_wr  = 1'b0;
        case (off_reg)
            OFF_BLUE:
            begin
                entry_new[3*LEVEL_W-1:2*LEVEL_W] = wr_level;
                level_wr = 1'b1;
            end
            OFF_RED:
            begin
                entry_new[2*LEVEL_W-1:LEVEL_W] = wr_level;
                level_wr = 1'b1;
            end
            OFF_GREEN:
            begin
                entry_new[LEVEL_W-1:0] = wr_level;
                level_wr = 1'b1;
            end
            default:
            begin
                entry_new = entry_old;
                level_wr  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        index_next   = index_reg;
        rd_data_next = 8'h00;
        notify_next  = 1'b0;
        if (hit_reg)
        begin
            if (type_reg == REQ_WRITE)
            begin
                case (off_reg)
                    OFF_IDX_HI: index_next[11:8] = wdata_reg[3:0];
                    OFF_IDX_LO: index_next[7:0]  = wdata_reg;
                    default:    index_next = index_reg;
                endcase
                notify_next = level_wr && (entry_new != entry_old) && full_color_reg;
            end
            else if (version_reg == VER_WRITE_ONLY)
            begin
                rd_data_next = RD_ALL_ONES;
            end
            else
            begin
                case (off_reg)
                    OFF_IDX_HI: rd_data_next = RD_UPPER_ONES | {4'h0, index_reg[11:8]};
                    OFF_IDX_LO: rd_data_next = RD_UPPER_ONES | index_reg[7:0];
                    OFF_BLUE:
                        rd_data_next = {4'hF, entry_old[3*LEVEL_W-1:2*LEVEL_W]};
                    OFF_RED:
                        rd_data_next = {4'hF, entry_old[2*LEVEL_W-1:LEVEL_W]};
                    default:
                        rd_data_next = {4'hF, entry_old[LEVEL_W-1:0]};
                endcase
            end
        end
    end

    // Sweep port during clearing, write-back of written levels afterwards
    assign ram_we    = cmd.clear_step ||
                       (cmd.resolve && hit_reg && (type_reg == REQ_WRITE) && level_wr);
    assign ram_waddr = cmd.clear_step ? clr_cnt_reg : slot;
    assign ram_wdata = cmd.clear_step ? '0 : entry_new;

    ipal_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PAL_ENTRIES)
    ) u_levels (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.capture),
        .raddr (slot),
        .rdata (entry_old)
    );

    assign status.clear_last = (clr_cnt_reg == PAL_ADDR_W'(PAL_ENTRIES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg    <= VER_RESET;
            full_color_reg <= 1'b0;
            index_reg      <= '0;
            clr_cnt_reg    <= '0;
            claimed_reg    <= 1'b0;
            notify_reg     <= 1'b0;
            rd_data_reg    <= 8'h00;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_IDX_VERSION)
                begin
                    version_reg <= cfg_data;
                end
                else if (cfg_index == CFG_IDX_FULL_COLOR)
                begin
                    full_color_reg <= cfg_data[0];
                end
            end
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.resolve)
            begin
                index_reg   <= index_next;
                rd_data_reg <= rd_data_next;
                claimed_reg <= hit_reg;
                notify_reg  <= notify_next;
            end
        end
    end

    // Request payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            hit_reg   <= (version_reg != VER_NONE) &&
                         (bus_addr >= ADDR_FIRST) && (bus_addr <= ADDR_LAST);
            type_reg  <= req_type;
            off_reg   <= 3'(bus_addr - ADDR_FIRST);
            wdata_reg <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;
    assign claimed = claimed_reg;
    assign notify  = notify_reg;

endmodule

/* bench/indexed_palette_register_file_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for indexed_palette_register_file_unit: a queued driver,
// a scoreboard monitor and a palette predictor built on ipal_pkg.
// Needs only the design sources; reads nothing at run time.
module indexed_palette_register_file_unit_tb
    import ipal_pkg::*;
();

    localparam logic [1:0] VER_READABLE = 2'd2;
    localparam logic [1:0] VER_SPARE    = 2'd3;
    localparam int HOLD_AT    = 150;
    localparam int HOLD_LEN   = 300;
    localparam int SETTLE     = 8;
    localparam int MAX_CYCLES = 500000;

    typedef struct packed {
        logic        req_kind;
        logic [15:0] addr;
        logic [7:0]  data;
    } bus_req_t;

    typedef struct packed {
        logic [7:0] rd_data;
        logic       claimed;
        logic       notify;
    } bus_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [1:0]  cfg_data = 2'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        req_type = 1'b0;
    logic [15:0] bus_addr = 16'd0;
    logic [7:0]  wr_data = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  rd_data;
    logic        claimed;
    logic        notify;

    // Predictor copy of the palette and its configuration
    logic [1:0]         mdl_version;
    logic               mdl_full_color;
    logic [INDEX_W-1:0] pal_index;
    logic [3:0]         blue_lv [PAL_ENTRIES];
    logic [3:0]         red_lv [PAL_ENTRIES];
    logic [3:0]         green_lv [PAL_ENTRIES];

    bus_req_t   pending_bus_reqs [$];
    bus_reply_t expected_bus_replies [$];

    int unsigned send_idle_pct = 25;
    int unsigned recv_stall_pct = 61;
    int unsigned n_accepted = 0;
    int unsigned n_errors = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    int unsigned cycle_cnt = 0;

    indexed_palette_register_file_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .bus_addr  (bus_addr),
        .wr_data   (wr_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rd_data   (rd_data),
        .claimed   (claimed),
        .notify    (notify)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one bus access to the palette copy and return the reply it gives
    function automatic bus_reply_t predict_bus_reply(input bus_req_t r);
        bus_reply_t              rep;
        logic [2:0]              off;
        logic [PAL_ADDR_W-1:0]   slot;
        logic [3:0]              lvl;
        logic                    changed;
        rep = '0;
        changed = 1'b0;
        slot = PAL_ADDR_W'(pal_index % PAL_ENTRIES);
        lvl = r.data[3:0];
        if (mdl_version != VER_NONE && r.addr >= ADDR_FIRST && r.addr <= ADDR_LAST)
        begin
            rep.claimed = 1'b1;
            off = 3'(r.addr - ADDR_FIRST);
            if (r.req_kind == REQ_WRITE)
            begin
                case (off)
                    OFF_IDX_HI: pal_index[11:8] = r.data[3:0];
                    OFF_IDX_LO: pal_index[7:0] = r.data;
                    OFF_BLUE:
                    begin
                        changed = (blue_lv[slot] != lvl);
                        blue_lv[slot] = lvl;
                    end
                    OFF_RED:
                    begin
                        changed = (red_lv[slot] != lvl);
                        red_lv[slot] = lvl;
                    end
                    default:
                    begin
                        changed = (green_lv[slot] != lvl);
                        green_lv[slot] = lvl;
                    end
                endcase
                rep.notify = changed && mdl_full_color;
            end
            else if (mdl_version == VER_WRITE_ONLY)
            begin
                rep.rd_data = RD_ALL_ONES;
            end
            else
            begin
                case (off)
                    OFF_IDX_HI: rep.rd_data = RD_UPPER_ONES | {4'h0, pal_index[11:8]};
                    OFF_IDX_LO: rep.rd_data = RD_UPPER_ONES | pal_index[7:0];
                    OFF_BLUE:   rep.rd_data = RD_UPPER_ONES | {4'h0, blue_lv[slot]};
                    OFF_RED:    rep.rd_data = RD_UPPER_ONES | {4'h0, red_lv[slot]};
                    default:    rep.rd_data = RD_UPPER_ONES | {4'h0, green_lv[slot]};
                endcase
            end
        end
        return rep;
    endfunction

    // Request driver: hold the payload until accepted, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin : drive_bus_reqs
        bus_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            n_accepted <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_bus_replies.push_back(
                    predict_bus_reply({req_type, bus_addr, wr_data}));
                n_accepted <= n_accepted + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_bus_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_bus_reqs.pop_front();
                    in_valid <= 1'b1;
                    req_type <= nxt.req_kind;
                    bus_addr <= nxt.addr;
                    wr_data <= nxt.data;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once enough requests have gone in
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && n_accepted >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Reply monitor: compare each reply against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : check_bus_replies
        bus_reply_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bus_replies.size() == 0)
                begin
                    $display("%0t: unexpected reply rd_data=%02h claimed=%0b notify=%0b",
                             $time, rd_data, claimed, notify);
                    n_errors <= n_errors + 1;
                end
                else
                begin
                    want = expected_bus_replies.pop_front();
                    if (rd_data !== want.rd_data || claimed !== want.claimed ||
                        notify !== want.notify)
                    begin
                        if (rd_data !== want.rd_data)
                            $display("%0t: rd_data mismatch, expected %02h, actual %02h",
                                     $time, want.rd_data, rd_data);
                        if (claimed !== want.claimed)
                            $display("%0t: claimed mismatch, expected %0b, actual %0b",
                                     $time, want.claimed, claimed);
                        if (notify !== want.notify)
                            $display("%0t: notify mismatch, expected %0b, actual %0b",
                                     $time, want.notify, notify);
                        n_errors <= n_errors + 1;
                    end
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= MAX_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic add_req(input logic kind, input logic [15:0] a, input logic [7:0] d);
        pending_bus_reqs.push_back({kind, a, d});
    endtask

    // Sample on the falling edge so every update of the rising edge has landed
    task automatic wait_drain();
        @(negedge clk);
        while (pending_bus_reqs.size() != 0 || in_valid || expected_bus_replies.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_IDX_VERSION)
            mdl_version = val;
        else
            mdl_full_color = val[0];
    endtask

    // Mostly decoded accesses over a few entries so levels get revisited;
    // the rest is full-range noise. Drain once midway when asked.
    task automatic run_random(input int count, input bit pause_midway);
        bus_req_t r;
        int       k;
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                wait_drain();
            k = $urandom_range(99);
            r.req_kind = 1'($urandom_range(0, 1));
            r.data = 8'($urandom);
            if (k < 12)
            begin
                r.addr = 16'($urandom);
            end
            else
            begin
                r.addr = ADDR_FIRST + 16'($urandom_range(0, 4));
                k = $urandom_range(99);
                case (3'(r.addr - ADDR_FIRST))
                    OFF_IDX_HI: if (k < 80) r.data[3:0] = 4'($urandom_range(0, 1));
                    OFF_IDX_LO: if (k < 80) r.data[7:0] = 8'($urandom_range(0, 7));
                    default:    if (k < 50) r.data[3:0] = 4'($urandom_range(0, 3));
                endcase
            end
            pending_bus_reqs.push_back(r);
        end
        wait_drain();
    endtask

    initial
    begin
        mdl_version = VER_READABLE;
        mdl_full_color = 1'b0;
        pal_index = '0;
        foreach (blue_lv[i])
        begin
            blue_lv[i] = '0;
            red_lv[i] = '0;
            green_lv[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset contents, index round trip, level writes with upper bits set
        add_req(REQ_READ, ADDR_FIRST, 8'h00);
        add_req(REQ_READ, ADDR_FIRST + 16'd1, 8'hFF);
        add_req(REQ_READ, ADDR_FIRST + 16'd2, 8'h00);
        add_req(REQ_READ, ADDR_FIRST + 16'd3, 8'h00);
        add_req(REQ_READ, ADDR_LAST, 8'h00);
        add_req(REQ_WRITE, ADDR_FIRST, 8'hFF);
        add_req(REQ_WRITE, ADDR_FIRST + 16'd1, 8'hFF);
        add_req(REQ_READ, ADDR_FIRST, 8'h00);
        add_req(REQ_READ, ADDR_FIRST + 16'd1, 8'h00);
        add_req(REQ_WRITE, ADDR_FIRST + 16'd2, 8'hFF);
        add_req(REQ_WRITE, ADDR_FIRST + 16'd3, 8'hA5);
        add_req(REQ_WRITE, ADDR_LAST, 8'h5A);
        add_req(REQ_READ, ADDR_FIRST + 16'd2, 8'h00);
        add_req(REQ_READ, ADDR_FIRST + 16'd3, 8'h00);
        add_req(REQ_READ, ADDR_LAST, 8'h00);
        add_req(REQ_WRITE, ADDR_FIRST, 8'h00);
        add_req(REQ_WRITE, ADDR_FIRST + 16'd1, 8'h00);
        add_req(REQ_READ, ADDR_FIRST + 16'd2, 8'h00);
        // Addresses just outside the window and the bus extremes
        add_req(REQ_READ, 16'h0000, 8'h00);
        add_req(REQ_WRITE, 16'hFFFF, 8'hFF);
        add_req(REQ_READ, ADDR_FIRST - 16'd1, 8'h00);
        add_req(REQ_WRITE, ADDR_LAST + 16'd1, 8'h00);
        wait_drain();

        // Spare version code reads like the readable one; notify only on change
        write_cfg(CFG_IDX_VERSION, VER_SPARE);
        write_cfg(CFG_IDX_FULL_COLOR, 1'b1);
        add_req(REQ_WRITE, ADDR_FIRST + 16'd2, 8'h07);
        add_req(REQ_WRITE, ADDR_FIRST + 16'd2, 8'h17);
        add_req(REQ_READ, ADDR_FIRST + 16'd2, 8'h00);
        add_req(REQ_WRITE, ADDR_LAST, 8'h0F);
        add_req(REQ_READ, ADDR_LAST, 8'h00);
        wait_drain();
        // Write-only palette: reads return all ones
        write_cfg(CFG_IDX_VERSION, VER_WRITE_ONLY);
        add_req(REQ_READ, ADDR_FIRST, 8'h00);
        add_req(REQ_WRITE, ADDR_FIRST + 16'd3, 8'h03);
        add_req(REQ_READ, ADDR_FIRST + 16'd3, 8'h00);
        wait_drain();
        // No palette: nothing is claimed
        write_cfg(CFG_IDX_VERSION, VER_NONE);
        add_req(REQ_READ, ADDR_FIRST + 16'd2, 8'h00);
        add_req(REQ_WRITE, ADDR_FIRST + 16'd2, 8'h05);
        wait_drain();

        write_cfg(CFG_IDX_VERSION, VER_READABLE);
        run_random(450, 1'b1);

        send_idle_pct = 61;
        recv_stall_pct = 25;
        write_cfg(CFG_IDX_VERSION, VER_WRITE_ONLY);
        write_cfg(CFG_IDX_FULL_COLOR, 1'b0);
        run_random(200, 1'b0);
        write_cfg(CFG_IDX_VERSION, VER_SPARE);
        write_cfg(CFG_IDX_FULL_COLOR, 1'b1);
        run_random(400, 1'b0);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_cfg(CFG_IDX_VERSION, VER_NONE);
        run_random(150, 1'b0);
        write_cfg(CFG_IDX_VERSION, VER_READABLE);
        write_cfg(CFG_IDX_FULL_COLOR, 1'b0);
        run_random(200, 1'b0);
        write_cfg(CFG_IDX_FULL_COLOR, 1'b1);
        run_random(250, 1'b0);

        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* indexed_palette_register_file_unit.f */
design/ipal_pkg.sv
design/ipal_ram.sv
design/ipal_ctrl.sv
design/ipal_datapath.sv
design/indexed_palette_register_file_unit.sv
bench/indexed_palette_register_file_unit_tb.sv
